/* design/vtpd_pkg.sv */
// shared types and constants for the vertex transform with perspective divide
`default_nettype none
package vtpd_pkg;

   localparam int WORD_W   = 32;
   localparam int NUM_REGS = 8;
   localparam int REG_W    = 64;
   localparam int ADDR_W   = 6;
   localparam int LANES    = 3;

   // reset values of the matrix registers (identity)
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   // sideband that travels beside the divider lanes
   typedef struct packed {
      logic                    valid;
      logic                    w_zero;
      logic                    sat;
      logic [LANES-1:0]        neg;
      logic [LANES*WORD_W-1:0] pass;
   } side_type;

endpackage
`default_nettype wire

/* design/vtpd_divider.sv */
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
`default_nettype none
module vtpd_divider
   import vtpd_pkg::*;
#(
   parameter int NUM_W = 48
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NUM_W-1:0]  num_i,
   input  wire logic [WORD_W-1:0] den_i,
   output logic      [NUM_W-1:0]  quo_o
);

   logic [WORD_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0]  nq_ff  [NUM_W];
   logic [WORD_W-1:0] den_ff [NUM_W];
   logic [WORD_W-1:0] rem_in [NUM_W];
   logic [NUM_W-1:0]  nq_in  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [WORD_W-1:0] rem_prev;
      logic [NUM_W-1:0]  nq_prev;
      logic [WORD_W-1:0] den_prev;
      logic [WORD_W:0]   trial;
      logic              fits;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num_i;
         assign den_prev = den_i;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign nq_prev  = nq_ff[s-1];
         assign den_prev = den_ff[s-1];
      end

      always_comb begin
         trial = {rem_prev, nq_prev[NUM_W-1]};
         fits  = trial >= {1'b0, den_prev};
         rem_in[s] = fits ? WORD_W'(trial - {1'b0, den_prev}) : trial[WORD_W-1:0];
         nq_in[s]  = {nq_prev[NUM_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            nq_ff[s]  <= nq_in[s];
            den_ff[s] <= den_prev;
         end
      end
   end

   assign quo_o = nq_ff[NUM_W-1];

endmodule
`default_nettype wire

/* design/vertex_transform_perspective_divide_top.sv */
// top level: 4x4 vertex transform followed by perspective divide
`default_nettype none
// Streams one vertex per cycle. Each request carries x, y, z in signed Q16.16
// (FRAC_BITS fraction bits) and yields one response with x/w, y/w, z/w (the
// transformed x, y, z when w is zero), a zero-w flag and a saturation flag.
// The pipe has one stage for the twelve 32x32 products, one for the sums,
// one for sign and magnitude, one stage per quotient bit in the restoring
// divider (32 + FRAC_BITS bits), and the output register. A new request is
// taken every cycle; the whole pipe holds only when a response waits and
// rsp_tready is low. The matrix sits in eight 64-bit registers at byte
// address 8*i; write them only while no request is in flight.
module vertex_transform_perspective_divide_top
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request: in_x [31:0], in_y [63:32], in_z [95:64]
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [95:0]       req_tdata,
   // response: out_x [31:0], out_y [63:32], out_z [95:64]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [95:0]       rsp_tdata,
   // response flags: w_was_zero [0], saturated [1]
   output logic      [1:0]        rsp_tuser,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [REG_W-1:0]  csr_pwdata,
   output logic      [REG_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int NUM_W = WORD_W + FRAC_BITS;  // divider numerator width
   localparam int PROD_W = 2 * WORD_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(33'sh1_8000_0000);
   localparam logic [NUM_W-1:0] QLIM = NUM_W'(33'h0_8000_0000);

   // ---------------- matrix registers ----------------
   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic             wr_en;
   logic [2:0]       wr_idx;

   assign csr_pready = 1'b1;
   assign wr_idx     = csr_paddr[ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = regs_ff[wr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= REG_RESET[i];
      end else if (wr_en) begin
         regs_ff[wr_idx] <= csr_pwdata;
      end
   end

   // coefficient (row, col): register 2*row + col/2, odd columns in the upper half
   logic signed [WORD_W-1:0] coef [4][4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         coef[r][0] = regs_ff[2*r][31:0];
         coef[r][1] = regs_ff[2*r][63:32];
         coef[r][2] = regs_ff[2*r+1][31:0];
         coef[r][3] = regs_ff[2*r+1][63:32];
      end
   end

   // pipe advances whenever the output register is free or being drained
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: products ----------------
   logic                     v1_ff;
   logic signed [PROD_W-1:0] p_ff [4][3];
   logic signed [PROD_W-1:0] p_in [4][3];
   logic signed [WORD_W-1:0] vin  [3];

   always_comb begin
      for (int c = 0; c < 3; c++) vin[c] = req_tdata[c*WORD_W +: WORD_W];
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 3; c++) p_in[r][c] = coef[r][c] * vin[c];
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   // ---------------- stage 2: floored sums, saturated ----------------
   logic                     v2_ff, sat2_ff, sat2_in;
   logic signed [WORD_W-1:0] s_ff [4];
   logic signed [WORD_W-1:0] s_in [4];
   logic signed [SUM_W-1:0]  tot  [4];

   always_comb begin
      sat2_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         // floor of the exact product sum, then add the translation column
         tot[r] = ((SUM_W'(p_ff[r][0]) + SUM_W'(p_ff[r][1]) + SUM_W'(p_ff[r][2]))
                   >>> FRAC_BITS) + SUM_W'(coef[r][3]);
         if (tot[r] > SMAX) begin
            s_in[r] = 32'sh7FFF_FFFF; sat2_in = 1'b1;
         end else if (tot[r] < SMIN) begin
            s_in[r] = 32'sh8000_0000; sat2_in = 1'b1;
         end else begin
            s_in[r] = tot[r][WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         sat2_ff <= sat2_in;
      end
   end

   // ---------------- stage 3: signs and magnitudes ----------------
   side_type          side3_ff, side3_in;
   logic [NUM_W-1:0]  num_ff [LANES];
   logic [NUM_W-1:0]  num_in [LANES];
   logic [WORD_W-1:0] den_ff, den_in;
   logic [WORD_W-1:0] mag    [LANES];

   always_comb begin
      den_in          = s_ff[3][WORD_W-1] ? WORD_W'(-s_ff[3]) : s_ff[3];
      side3_in.valid  = v2_ff;
      side3_in.w_zero = (s_ff[3] == '0);
      side3_in.sat    = sat2_ff;
      for (int l = 0; l < LANES; l++) begin
         mag[l] = s_ff[l][WORD_W-1] ? WORD_W'(-s_ff[l]) : s_ff[l];
         num_in[l] = {mag[l], {FRAC_BITS{1'b0}}};
         side3_in.neg[l] = s_ff[l][WORD_W-1] ^ s_ff[3][WORD_W-1];
         side3_in.pass[l*WORD_W +: WORD_W] = s_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff.valid <= 1'b0;
      end else if (en) begin
         side3_ff <= side3_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
      end
   end

   // ---------------- divider lanes and matching sideband line ----------------
   logic [NUM_W-1:0] quo [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vtpd_divider #(.NUM_W(NUM_W)) u_div (
         .clock (clock),
         .en    (en),
         .num_i (num_ff[l]),
         .den_i (den_ff),
         .quo_o (quo[l])
      );
   end

   side_type side_ff [NUM_W];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_W; s++) side_ff[s].valid <= 1'b0;
      end else if (en) begin
         side_ff[0] <= side3_ff;
         for (int s = 1; s < NUM_W; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // ---------------- output: sign fix, clamp, zero-w select ----------------
   side_type          last;
   logic [95:0]       data_in;
   logic              sat_in;
   logic [NUM_W-1:0]  negq;
   logic [NUM_W-1:0]  q;

   assign last = side_ff[NUM_W-1];

   always_comb begin
      sat_in  = last.sat;
      data_in = last.pass;
      negq    = '0;
      q       = '0;
      if (!last.w_zero) begin
         for (int l = 0; l < LANES; l++) begin
            q    = quo[l];
            negq = ~q + NUM_W'(1);
            if (last.neg[l]) begin
               if (q > QLIM) begin
                  data_in[l*WORD_W +: WORD_W] = 32'h8000_0000; sat_in = 1'b1;
               end else begin
                  data_in[l*WORD_W +: WORD_W] = negq[WORD_W-1:0];
               end
            end else begin
               if (q >= QLIM) begin
                  data_in[l*WORD_W +: WORD_W] = 32'h7FFF_FFFF; sat_in = 1'b1;
               end else begin
                  data_in[l*WORD_W +: WORD_W] = q[WORD_W-1:0];
               end
            end
         end
      end
   end

   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= last.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= data_in;
         rsp_user_ff <= {sat_in, last.w_zero};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

/* design/vtpd_checker.sv */
// port-level checker for the vertex transform top, with its bind
`default_nettype none
module vtpd_checker
   import vtpd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        csr_pready
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty output stage always takes a request
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with free output");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr pready low");

endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_vtpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
`default_nettype wire
